// ===== rtl/lhto_pkg.sv =====
// shared types, codes and letter helpers for the letter hash table
package lhto_pkg;

    localparam int PRIME_SLOTS = 26;
    localparam int CHAR_W      = 8;
    localparam int HOME_W      = 5;
    localparam int SLOT_W      = 7;

    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_NOT_LETTER = 3'd5;

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] letter;
    } lhto_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } lhto_out_t;

    // query token that walks the cell row
    typedef struct packed {
        logic              valid;
        logic [1:0]        command;
        logic [CHAR_W-1:0] letter;
        logic [HOME_W-1:0] home;
        logic              home_used;
        logic              hit;
        logic              has_empty;
        logic              has_cand;
        logic [CHAR_W-1:0] cand_char;
    } lhto_tok_t;

    // broadcast update to the cells
    typedef struct packed {
        logic              wr_en;
        logic              clr_en;
        logic [CHAR_W-1:0] wr_char;
        logic [HOME_W-1:0] wr_home;
    } lhto_wr_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] f;
        f = c;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            f = c + CASE_OFS;
        end
        return f;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] f;
        f = fold_case(c);
        return (f >= LOWER_A) && (f <= LOWER_Z);
    endfunction

    function automatic logic [HOME_W-1:0] home_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = fold_case(c) - LOWER_A;
        return d[HOME_W-1:0];
    endfunction

endpackage

// ===== rtl/lhto_cell.sv =====
// one table slot: stored entry plus one stage of the query token path
module lhto_cell #(
    parameter int IDX_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     slot,
    input  lhto_pkg::lhto_tok_t  tok_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     empty_idx_in,
    input  logic [IDX_W-1:0]     cand_idx_in,
    output lhto_pkg::lhto_tok_t  tok_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     empty_idx_out,
    output logic [IDX_W-1:0]     cand_idx_out,
    input  lhto_pkg::lhto_wr_t   wr,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [IDX_W-1:0]     clr_idx
);
    import lhto_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic [HOME_W-1:0] home_reg;
    lhto_tok_t         tok_reg, tok_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]  cand_idx_reg, cand_idx_next;
    logic              is_ovf;
    logic              occupied;

    assign is_ovf   = (slot >= IDX_W'(PRIME_SLOTS));
    assign occupied = (char_reg != '0);

    always_comb
    begin
        tok_next       = tok_in;
        hit_idx_next   = hit_idx_in;
        empty_idx_next = empty_idx_in;
        cand_idx_next  = cand_idx_in;
        if (tok_in.valid)
        begin
            if (slot == IDX_W'(tok_in.home))
            begin
                tok_next.home_used = occupied;
            end
            if (occupied && char_reg == tok_in.letter)
            begin
                tok_next.hit = 1'b1;
                hit_idx_next = slot;
            end
            // first free overflow slot
            if (is_ovf && !occupied && !tok_in.has_empty)
            begin
                tok_next.has_empty = 1'b1;
                empty_idx_next     = slot;
            end
            // first overflow entry sharing the home, for promotion
            if (is_ovf && occupied && home_reg == tok_in.home && !tok_in.has_cand)
            begin
                tok_next.has_cand  = 1'b1;
                tok_next.cand_char = char_reg;
                cand_idx_next      = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
            home_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr.wr_en && wr_idx == slot)
            begin
                char_reg <= wr.wr_char;
                home_reg <= wr.wr_home;
            end
            else if (wr.clr_en && clr_idx == slot)
            begin
                char_reg <= '0;
                home_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        empty_idx_reg <= empty_idx_next;
        cand_idx_reg  <= cand_idx_next;
    end

    assign tok_out       = tok_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign empty_idx_out = empty_idx_reg;
    assign cand_idx_out  = cand_idx_reg;

endmodule

// ===== rtl/lhto_ctrl.sv =====
// command sequencer: launches the query token, decides the result, updates the cells
module lhto_ctrl #(
    parameter int TABLE_SLOTS = 128,
    parameter int IDX_W       = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lhto_pkg::lhto_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lhto_pkg::lhto_out_t  out_data,
    output lhto_pkg::lhto_tok_t  tok_head,
    input  lhto_pkg::lhto_tok_t  tok_tail,
    input  logic [IDX_W-1:0]     hit_idx,
    input  logic [IDX_W-1:0]     empty_idx,
    input  logic [IDX_W-1:0]     cand_idx,
    output lhto_pkg::lhto_wr_t   wr,
    output logic [IDX_W-1:0]     wr_idx,
    output logic [IDX_W-1:0]     clr_idx
);
    import lhto_pkg::*;

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {IDLE, SCAN, PUSH} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    lhto_out_t        res_reg, res_next;
    lhto_out_t        out_data_reg;
    logic             out_valid_reg;
    logic             tail_fire;
    logic             found;
    logic             cnt_inc, cnt_dec;
    logic             out_free;

    assign in_ready  = (state_reg == IDLE);
    assign tail_fire = (state_reg == SCAN) && tok_tail.valid;
    assign found     = tok_tail.home_used && tok_tail.hit;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        tok_head           = '0;
        tok_head.valid     = in_valid && in_ready;
        tok_head.command   = in_data.command;
        tok_head.letter    = in_data.letter;
        tok_head.home      = home_of(in_data.letter);
    end

    always_comb
    begin
        res_next = '0;
        wr       = '0;
        wr_idx   = '0;
        clr_idx  = '0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        if (!is_letter(tok_tail.letter))
        begin
            res_next.status = ST_NOT_LETTER;
        end
        else
        begin
            case (tok_tail.command)
                CMD_FIND:
                begin
                    if (found)
                    begin
                        res_next.slot_index = SLOT_W'(hit_idx);
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end
                CMD_INSERT:
                begin
                    if (count_reg == CNT_W'(TABLE_SLOTS))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else if (found)
                    begin
                        res_next.status = ST_DUPLICATE;
                    end
                    else if (!tok_tail.home_used)
                    begin
                        wr.wr_en            = 1'b1;
                        wr_idx              = IDX_W'(tok_tail.home);
                        cnt_inc             = 1'b1;
                        res_next.slot_index = SLOT_W'(tok_tail.home);
                    end
                    else if (tok_tail.has_empty)
                    begin
                        wr.wr_en            = 1'b1;
                        wr_idx              = empty_idx;
                        cnt_inc             = 1'b1;
                        res_next.slot_index = SLOT_W'(empty_idx);
                    end
                    else
                    begin
                        res_next.status = ST_FULL;
                    end
                    wr.wr_char = tok_tail.letter;
                    wr.wr_home = tok_tail.home;
                end
                CMD_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        cnt_dec             = 1'b1;
                        res_next.slot_index = SLOT_W'(hit_idx);
                        wr.wr_en            = 1'b1;
                        wr_idx              = hit_idx;
                        // prime slot freed: pull the lowest overflow entry with that home
                        if (hit_idx < IDX_W'(PRIME_SLOTS) && tok_tail.has_cand)
                        begin
                            wr.wr_char = tok_tail.cand_char;
                            wr.wr_home = tok_tail.home;
                            wr.clr_en  = 1'b1;
                            clr_idx    = cand_idx;
                        end
                    end
                end
                default:
                begin
                    res_next.status = ST_NOT_FOUND;
                end
            endcase
        end
        if (!tail_fire)
        begin
            wr.wr_en  = 1'b0;
            wr.clr_en = 1'b0;
            cnt_inc   = 1'b0;
            cnt_dec   = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (state_reg == PUSH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (tok_tail.valid)
                    begin
                        res_reg   <= res_next;
                        state_reg <= PUSH;
                    end
                end
                PUSH:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= res_reg;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_tail.valid |-> state_reg == SCAN)
        else $error("token left the row outside a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS))
        else $error("item count beyond table size");

    a_promote_split: assert property (@(posedge clk) disable iff (!rst_n)
        wr.wr_en && wr.clr_en |-> wr_idx != clr_idx)
        else $error("promotion writes and clears the same slot");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(tail_fire))
        else $error("item count moved without a finished scan");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_OK |-> out_data_reg.slot_index == '0)
        else $error("slot index set on a failed command");

endmodule

// ===== rtl/letter_hash_table_with_overflow.sv =====
// top level: letter hash table with overflow area, built as a row of slot cells
//
//  channel | signals                        | transfer
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | command and letter
//  out     | out_valid, out_ready, out_data | status and slot_index
//
//  out_valid rises after the query token walks one cell per cycle through all slots, the
//  sequencer registers the result, and the result moves on to the output register once free
//  the next input transfer can come once the result has moved to the output register
//  one command in flight at a time; in_ready is high only while idle
//  a finished result waits in the output register while the next command runs;
//  the next result then holds the sequencer, and so the input, until out_ready
//  reset clears every slot, the item count and the output register at once
module letter_hash_table_with_overflow #(
    parameter int TABLE_SLOTS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lhto_pkg::lhto_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lhto_pkg::lhto_out_t  out_data
);
    import lhto_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    // token path: stage 0 is the launch from the sequencer, stage k+1 leaves cell k
    lhto_tok_t        tok_chain   [TABLE_SLOTS+1];
    logic [IDX_W-1:0] hit_chain   [TABLE_SLOTS+1];
    logic [IDX_W-1:0] empty_chain [TABLE_SLOTS+1];
    logic [IDX_W-1:0] cand_chain  [TABLE_SLOTS+1];

    // broadcast update applied when the token leaves the last cell
    lhto_wr_t         wr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] clr_idx;

    // launched token starts with no recorded slots
    assign hit_chain[0]   = '0;
    assign empty_chain[0] = '0;
    assign cand_chain[0]  = '0;

    lhto_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .tok_head  (tok_chain[0]),
        .tok_tail  (tok_chain[TABLE_SLOTS]),
        .hit_idx   (hit_chain[TABLE_SLOTS]),
        .empty_idx (empty_chain[TABLE_SLOTS]),
        .cand_idx  (cand_chain[TABLE_SLOTS]),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .clr_idx   (clr_idx)
    );

    // one cell per slot; prime slots come first, then the overflow area
    for (genvar k = 0; k < TABLE_SLOTS; k++)
    begin : g_cell
        lhto_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .slot          (IDX_W'(k)),
            .tok_in        (tok_chain[k]),
            .hit_idx_in    (hit_chain[k]),
            .empty_idx_in  (empty_chain[k]),
            .cand_idx_in   (cand_chain[k]),
            .tok_out       (tok_chain[k+1]),
            .hit_idx_out   (hit_chain[k+1]),
            .empty_idx_out (empty_chain[k+1]),
            .cand_idx_out  (cand_chain[k+1]),
            .wr            (wr),
            .wr_idx        (wr_idx),
            .clr_idx       (clr_idx)
        );
    end

endmodule

// ===== dv/letter_hash_table_with_overflow_tb.sv =====
// testbench for the letter hash table: directed and random commands checked slot by slot
module letter_hash_table_with_overflow_tb;
    import lhto_pkg::*;

    localparam int TABLE_SLOTS = 128;

    // the command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // receiver hold-off, long enough for the block to stall its input
    localparam int HOLD_CYCLES = 1500;

    // settle time after the last result, a bit over one full table walk
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 40;

    // generous bound on the whole run, in time units
    localparam int RUN_LIMIT = 10_000_000;

    // slot-level model of the table plus the queue of replies still to come
    class letter_table_checker #(int SLOTS = 128);
        logic [CHAR_W-1:0] held_char [SLOTS];
        logic [HOME_W-1:0] held_home [SLOTS];
        int unsigned       held_count;
        lhto_out_t         replies_due [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                held_char[i] = '0;
                held_home[i] = '0;
            end
            held_count = 0;
            mismatches = 0;
        endfunction

        // case-folded home slot; returns 0 for anything that is not a letter
        function bit home_slot(input logic [CHAR_W-1:0] c, output logic [HOME_W-1:0] h);
            logic [CHAR_W-1:0] low;
            low = c;
            if (c >= UPPER_A && c <= UPPER_Z)
            begin
                low = c + CASE_OFS;
            end
            h = '0;
            if (low < LOWER_A || low > LOWER_Z)
            begin
                return 1'b0;
            end
            h = HOME_W'(low - LOWER_A);
            return 1'b1;
        endfunction

        // slot holding c, or SLOTS when absent; an empty home slot ends the search
        function int slot_of(input logic [CHAR_W-1:0] c, input logic [HOME_W-1:0] h);
            int idx;
            if (held_char[h] == c)
            begin
                return int'(h);
            end
            if (held_char[h] == '0)
            begin
                return SLOTS;
            end
            idx = int'(h);
            for (int i = 1; i < SLOTS; i++)
            begin
                idx = (idx + 1) % SLOTS;
                if (held_char[idx] == c)
                begin
                    return idx;
                end
            end
            return SLOTS;
        endfunction

        // apply one accepted command to the model and queue its reply
        function void take_command(input lhto_in_t cmd);
            logic [HOME_W-1:0] h;
            lhto_out_t         reply;
            int                idx;
            reply.status     = ST_OK;
            reply.slot_index = '0;
            idx              = SLOTS;
            if (!home_slot(cmd.letter, h))
            begin
                reply.status = ST_NOT_LETTER;
            end
            else
            begin
                case (cmd.command)
                    CMD_FIND:
                    begin
                        idx = slot_of(cmd.letter, h);
                        if (idx >= SLOTS)
                        begin
                            reply.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (held_count >= SLOTS)
                        begin
                            reply.status = ST_FULL;
                        end
                        else if (slot_of(cmd.letter, h) < SLOTS)
                        begin
                            reply.status = ST_DUPLICATE;
                        end
                        else
                        begin
                            if (held_char[h] == '0)
                            begin
                                idx = int'(h);
                            end
                            else
                            begin
                                for (int i = PRIME_SLOTS; i < SLOTS; i++)
                                begin
                                    if (held_char[i] == '0)
                                    begin
                                        idx = i;
                                        break;
                                    end
                                end
                            end
                            if (idx >= SLOTS)
                            begin
                                reply.status = ST_FULL;
                            end
                            else
                            begin
                                held_char[idx] = cmd.letter;
                                held_home[idx] = h;
                                held_count++;
                            end
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (held_count == 0)
                        begin
                            reply.status = ST_EMPTY;
                        end
                        else
                        begin
                            idx = slot_of(cmd.letter, h);
                            if (idx >= SLOTS)
                            begin
                                reply.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                held_char[idx] = '0;
                                held_home[idx] = '0;
                                held_count--;
                                // a freed prime slot takes the lowest overflow entry of its home
                                if (idx < PRIME_SLOTS)
                                begin
                                    for (int i = PRIME_SLOTS; i < SLOTS; i++)
                                    begin
                                        if (held_char[i] != '0 && held_home[i] == idx)
                                        begin
                                            held_char[idx] = held_char[i];
                                            held_home[idx] = held_home[i];
                                            held_char[i]   = '0;
                                            held_home[i]   = '0;
                                            break;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        reply.status = ST_NOT_FOUND;
                    end
                endcase
            end
            if (reply.status == ST_OK)
            begin
                reply.slot_index = SLOT_W'(idx);
            end
            replies_due.push_back(reply);
        endfunction

        // compare one result transfer with the oldest reply due
        function void check_reply(input lhto_out_t got);
            lhto_out_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, got.status, got.slot_index);
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
            begin
                mismatches++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
            if (got.slot_index !== want.slot_index)
            begin
                mismatches++;
                $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                         $time, want.slot_index, got.slot_index);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    lhto_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    lhto_out_t   out_data;

    // idle rates in percent, set by the stimulus per phase
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // long receiver hold-off: requested by the stimulus, carried out by the receiver
    bit          hold_wanted;
    bit          hold_taken;

    letter_table_checker #(TABLE_SLOTS) table_model;

    letter_hash_table_with_overflow #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls per cycle, plus one long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // every result transfer is checked against the model
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            table_model.check_reply(out_data);
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // offer one command and hold it until the input transfer happens
    task automatic issue_command(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch);
        lhto_in_t item;
        item.command = cmd;
        item.letter  = ch;
        // gaps of up to a bit over one table walk so they land on every phase of the scan
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(TABLE_SLOTS + 4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        table_model.take_command(item);
    endtask

    // letter mostly near a moving focus home so entries collide and overflow
    function automatic logic [CHAR_W-1:0] pool_letter(input int unsigned focus);
        int unsigned h;
        if ($urandom_range(3, 0) != 0)
        begin
            h = (focus + $urandom_range(3, 0)) % PRIME_SLOTS;
        end
        else
        begin
            h = $urandom_range(PRIME_SLOTS - 1, 0);
        end
        return ($urandom_range(1, 0) ? LOWER_A : UPPER_A) + CHAR_W'(h);
    endfunction

    // any character outside both letter ranges, edges of the ranges favored
    function automatic logic [CHAR_W-1:0] odd_character();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(3, 0))
            0: c = '0;
            1: c = '1;
            2:
            begin
                case ($urandom_range(3, 0))
                    0:       c = UPPER_A - 8'd1;
                    1:       c = UPPER_Z + 8'd1;
                    2:       c = LOWER_A - 8'd1;
                    default: c = LOWER_Z + 8'd1;
                endcase
            end
            default:
            begin
                // setting the case bit maps both letter ranges onto the lower one
                do
                begin
                    c = CHAR_W'($urandom_range(255, 0));
                end
                while ((c | CASE_OFS) >= LOWER_A && (c | CASE_OFS) <= LOWER_Z);
            end
        endcase
        return c;
    endfunction

    // random commands: mostly well-formed letters, some junk and unused codes
    task automatic random_batch(input int count, input int insert_pct, input int delete_pct);
        int unsigned focus;
        int unsigned roll;
        int unsigned pick;
        logic [1:0]  cmd;
        focus = $urandom_range(PRIME_SLOTS - 1, 0);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                focus = $urandom_range(PRIME_SLOTS - 1, 0);
            end
            roll = $urandom_range(99, 0);
            if (roll < 6)
            begin
                issue_command(2'($urandom_range(3, 0)), odd_character());
            end
            else if (roll < 9)
            begin
                issue_command(CMD_UNUSED, pool_letter(focus));
            end
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < insert_pct)
                begin
                    cmd = CMD_INSERT;
                end
                else if (pick < insert_pct + delete_pct)
                begin
                    cmd = CMD_DELETE;
                end
                else
                begin
                    cmd = CMD_FIND;
                end
                issue_command(cmd, pool_letter(focus));
            end
        end
    endtask

    initial
    begin
        table_model   = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        send_idle_pct = 12;
        recv_idle_pct = 57;
        hold_wanted   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: find misses, delete reports empty
        issue_command(CMD_FIND, "A");
        issue_command(CMD_DELETE, "A");
        // zero is not a letter
        issue_command(CMD_INSERT, 8'h00);
        // home slot, then duplicate, then same home in other case goes to overflow
        issue_command(CMD_INSERT, "A");
        issue_command(CMD_INSERT, "A");
        issue_command(CMD_INSERT, "a");
        issue_command(CMD_FIND, "a");
        // empty home slot means absent
        issue_command(CMD_FIND, "z");
        issue_command(CMD_INSERT, "Z");
        issue_command(CMD_INSERT, "z");
        issue_command(CMD_FIND, "z");
        // occupied home but letter absent: full scan with wrap
        issue_command(CMD_INSERT, "M");
        issue_command(CMD_FIND, "m");
        // prime delete promotes the overflow entry of the same home
        issue_command(CMD_DELETE, "A");
        issue_command(CMD_FIND, "a");
        issue_command(CMD_DELETE, "m");
        // prime delete with nothing to promote leaves the slot empty
        issue_command(CMD_DELETE, "M");
        issue_command(CMD_FIND, "M");
        // unused command code, with and without a letter
        issue_command(CMD_UNUSED, "A");
        issue_command(CMD_UNUSED, 8'hFF);
        // characters outside the letter ranges, most just outside their edges
        issue_command(CMD_FIND, 8'h80);
        issue_command(CMD_DELETE, UPPER_A - 8'd1);
        issue_command(CMD_INSERT, UPPER_Z + 8'd1);
        issue_command(CMD_FIND, LOWER_A - 8'd1);
        issue_command(CMD_DELETE, LOWER_Z + 8'd1);
        // prime delete promotes the overflow entry of the same home, then find the promoted entry
        issue_command(CMD_DELETE, "Z");
        issue_command(CMD_FIND, "z");

        // phase one: mostly inserts, receiver stalls often
        random_batch(200, 55, 15);

        // phase two: sender idles often, receiver holds off once for a long stretch
        send_idle_pct = 57;
        recv_idle_pct = 12;
        hold_wanted   = 1'b1;
        random_batch(200, 35, 35);

        // phase three: back to back transfers on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_batch(200, 40, 30);

        in_valid <= 1'b0;
        @(posedge clk);
        while (table_model.replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_model.mismatches == 0 && table_model.replies_due.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
